@@ sv/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the address cache with request retry.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int CACHE_ENTRIES   = 32;
    localparam int REQUEST_ENTRIES = 16;
    localparam int CIDX_W = $clog2(CACHE_ENTRIES);
    localparam int RIDX_W = $clog2(REQUEST_ENTRIES);

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_QUEUE  = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    localparam logic [3:0] ST_HIT      = 4'd0;
    localparam logic [3:0] ST_MISS     = 4'd1;
    localparam logic [3:0] ST_INSERTED = 4'd2;
    localparam logic [3:0] ST_FULL     = 4'd3;
    localparam logic [3:0] ST_QNEW     = 4'd4;
    localparam logic [3:0] ST_QOLD     = 4'd5;
    localparam logic [3:0] ST_QFULL    = 4'd6;
    localparam logic [3:0] ST_RETRY    = 4'd7;
    localparam logic [3:0] ST_UNREACH  = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_LIMIT    = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [47:0] found_mac;
        logic [31:0] event_ip;
        logic        had_pending;
        logic [3:0]  request_slot;
        logic        last;
    } t_out;

    // broadcast command from the sequencer to every cell
    typedef struct packed {
        logic        wr;       // write into claimed slot
        logic        clr_hit;  // invalidate matching slot
        logic        age;      // tick aging / request aging step
        logic [31:0] ip;
        logic [47:0] mac;
        logic [7:0]  timeout;
        logic [2:0]  limit;
        logic [1:0]  interval;
    } t_cmd;

endpackage

@@ sv/arp_cache_with_request_retry_core.sv @@
// ----------------------------------------------------------------------------
// arp_cache_with_request_retry_core
// Address cache and pending request table built as chains of slot cells.
// ----------------------------------------------------------------------------
//  channel   | signals                         | transfer
//  command   | i_start, o_busy, i_cmd          | i_start && !o_busy
//  result    | o_valid, o_result               | o_valid (one cycle)
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data | i_cfg_we
//
// Lookup, insert and queue keep busy high only while in S_EXEC: the command is
// broadcast into the cell chains (free-slot token and hit chain ripple
// through) and the result is registered at the end of that state.
// A tick passes through S_EXEC, S_DRAIN and S_DONE, staying in S_DRAIN while retried or dropped requests remain: the
// sequencer drains cell events one a cycle by lowest slot, then sweep done.
// Reset is synchronous: it clears valid bits, event flags and the sequencer and presets the config registers.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module arp_cache_with_request_retry_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  arpc_pkg::t_in      i_cmd,
    output logic               o_valid,
    output arpc_pkg::t_out     o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    localparam int CE = arpc_pkg::CACHE_ENTRIES;
    localparam int RE = arpc_pkg::REQUEST_ENTRIES;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    arpc_pkg::t_in   r_in;
    arpc_pkg::t_out  r_out, n_out;
    logic            r_ovalid, n_ovalid;
    logic [7:0]      r_timeout;
    logic [2:0]      r_limit;
    logic [1:0]      r_interval;
    arpc_pkg::t_cmd  w_cmd;

    logic [CE:0]     w_cfree;
    logic [CE:0]     w_chit;
    logic [47:0]     w_cmac [CE+1];
    logic [RE:0]     w_rfree;
    logic [RE-1:0]   w_rmatch, w_rvalid, w_revt, w_rdrop, w_rack;
    logic [31:0]     w_rip [RE];
    logic            w_any_match;
    logic [arpc_pkg::RIDX_W-1:0] w_match_idx, w_evt_idx;

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_result = r_out;

    // broadcast command
    always_comb begin
        w_cmd          = '0;
        w_cmd.ip       = r_in.ip_addr;
        w_cmd.mac      = r_in.mac_addr;
        w_cmd.timeout  = r_timeout;
        w_cmd.limit    = r_limit;
        w_cmd.interval = r_interval;
        if (r_state == S_EXEC) begin
            w_cmd.age     = (r_in.kind == arpc_pkg::KIND_TICK);
            w_cmd.clr_hit = (r_in.kind == arpc_pkg::KIND_INSERT);
        end
    end

    // cache chain
    assign w_cfree[0] = 1'b0;
    assign w_chit[0]  = 1'b0;
    assign w_cmac[0]  = '0;
    arpc_pkg::t_cmd w_ccmd;
    always_comb begin
        w_ccmd    = w_cmd;
        w_ccmd.wr = (r_state == S_EXEC) && (r_in.kind == arpc_pkg::KIND_INSERT);
    end
    for (genvar g = 0; g < CE; g++) begin : g_cache
        arpc_cache_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_ccmd),
            .i_free_in  (w_cfree[g]),
            .o_free_out (w_cfree[g+1]),
            .i_hit_in   (w_chit[g]),
            .i_mac_in   (w_cmac[g]),
            .o_hit_out  (w_chit[g+1]),
            .o_mac_out  (w_cmac[g+1])
        );
    end

    // request chain
    assign w_rfree[0] = 1'b0;
    arpc_pkg::t_cmd w_rcmd;
    always_comb begin
        w_rcmd    = w_cmd;
        w_rcmd.wr = (r_state == S_EXEC) && (r_in.kind == arpc_pkg::KIND_QUEUE)
                    && !w_any_match;
    end
    for (genvar g = 0; g < RE; g++) begin : g_req
        arpc_req_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_rcmd),
            .i_free_in  (w_rfree[g]),
            .o_free_out (w_rfree[g+1]),
            .i_ack      (w_rack[g]),
            .o_match    (w_rmatch[g]),
            .o_valid    (w_rvalid[g]),
            .o_evt      (w_revt[g]),
            .o_evt_drop (w_rdrop[g]),
            .o_ip       (w_rip[g])
        );
    end

    // first matching request and first pending event
    always_comb begin
        w_any_match = 1'b0;
        w_match_idx = '0;
        w_evt_idx   = '0;
        for (int k = RE - 1; k >= 0; k--) begin
            if (w_rmatch[k]) begin
                w_any_match = 1'b1;
                w_match_idx = k[arpc_pkg::RIDX_W-1:0];
            end
            if (w_revt[k]) begin
                w_evt_idx = k[arpc_pkg::RIDX_W-1:0];
            end
        end
    end

    // first free request slot index
    logic [arpc_pkg::RIDX_W-1:0] w_free_idx;
    always_comb begin
        w_free_idx = '0;
        for (int k = RE - 1; k >= 0; k--) begin
            if (!w_rvalid[k]) begin
                w_free_idx = k[arpc_pkg::RIDX_W-1:0];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_out    = r_out;
        n_ovalid = 1'b0;
        w_rack   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out              = '0;
                n_out.event_ip     = r_in.ip_addr;
                n_out.last         = 1'b1;
                n_state            = S_IDLE;
                n_ovalid           = 1'b1;
                case (r_in.kind)
                    arpc_pkg::KIND_LOOKUP: begin
                        n_out.status    = w_chit[CE] ? arpc_pkg::ST_HIT
                                                     : arpc_pkg::ST_MISS;
                        n_out.found_mac = w_chit[CE] ? w_cmac[CE] : '0;
                    end
                    arpc_pkg::KIND_INSERT: begin
                        n_out.status       = w_cfree[CE] ? arpc_pkg::ST_INSERTED
                                                          : arpc_pkg::ST_FULL;
                        n_out.had_pending  = w_any_match;
                        n_out.request_slot = 4'(w_match_idx);
                    end
                    arpc_pkg::KIND_QUEUE: begin
                        if (w_any_match) begin
                            n_out.status       = arpc_pkg::ST_QOLD;
                            n_out.request_slot = 4'(w_match_idx);
                        end else if (w_rfree[RE]) begin
                            n_out.status       = arpc_pkg::ST_QNEW;
                            n_out.request_slot = 4'(w_free_idx);
                        end else begin
                            n_out.status       = arpc_pkg::ST_QFULL;
                        end
                    end
                    default: begin
                        n_ovalid = 1'b0;
                        n_state  = S_DRAIN;
                    end
                endcase
            end
            S_DRAIN: begin
                n_out = '0;
                if (|w_revt) begin
                    n_ovalid           = 1'b1;
                    n_out.status       = w_rdrop[w_evt_idx] ? arpc_pkg::ST_UNREACH
                                                            : arpc_pkg::ST_RETRY;
                    n_out.event_ip     = w_rip[w_evt_idx];
                    n_out.request_slot = 4'(w_evt_idx);
                    w_rack[w_evt_idx]  = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_ovalid       = 1'b1;
                n_out          = '0;
                n_out.status   = arpc_pkg::ST_DONE;
                n_out.event_ip = r_in.ip_addr;
                n_out.last     = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_timeout  <= 8'd15;
            r_limit    <= 3'd5;
            r_interval <= 2'd1;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    arpc_pkg::REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    arpc_pkg::REG_LIMIT:    r_limit    <= i_cfg_data[2:0];
                    arpc_pkg::REG_INTERVAL: r_interval <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_start && !o_busy) begin
            r_in <= i_cmd;
        end
    end

    // assertions
    a_ack_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_rack)) else $error("more than one event taken");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> (r_state == S_IDLE))
        else $error("last result while still busy");
    a_no_evt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_revt == '0))
        else $error("request event left after sweep");
endmodule

@@ sv/arpc_cache_cell.sv @@
// ----------------------------------------------------------------------------
// arpc_cache_cell
// One cache slot: holds a mapping, compares it and ages it. A claim token
// ripples down the chain so the first free slot takes a write.
// ----------------------------------------------------------------------------
module arpc_cache_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  arpc_pkg::t_cmd       i_cmd,
    input  logic                 i_free_in,   // a lower slot is free
    output logic                 o_free_out,
    input  logic                 i_hit_in,    // hit data from lower slots
    input  logic [47:0]          i_mac_in,
    output logic                 o_hit_out,
    output logic [47:0]          o_mac_out
);
    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [7:0]  r_age;
    logic        w_match;
    logic        w_claim;
    logic [7:0]  n_age;

    assign w_match    = r_valid && (r_ip == i_cmd.ip);
    assign w_claim    = !r_valid && !i_free_in;
    assign o_free_out = i_free_in || !r_valid;
    // later slot wins, so a match here overrides lower ones
    assign o_hit_out  = i_hit_in || w_match;
    assign o_mac_out  = w_match ? r_mac : i_mac_in;
    assign n_age      = (r_age == 8'hFF) ? r_age : r_age + 8'd1;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr && w_claim) begin
            r_valid <= 1'b1;
        end else if (i_cmd.age && r_valid && (n_age > i_cmd.timeout)) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_claim) begin
            r_ip  <= i_cmd.ip;
            r_mac <= i_cmd.mac;
            r_age <= 8'd0;
        end else if (i_cmd.age && r_valid) begin
            r_age <= n_age;
        end
    end
endmodule

@@ sv/arpc_req_cell.sv @@
// ----------------------------------------------------------------------------
// arpc_req_cell
// One pending request slot. On a tick it updates itself and, when due, raises an event
// that the sequencer drains in slot order.
// ----------------------------------------------------------------------------
module arpc_req_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  arpc_pkg::t_cmd       i_cmd,
    input  logic                 i_free_in,
    output logic                 o_free_out,
    input  logic                 i_ack,       // event of this slot taken
    output logic                 o_match,
    output logic                 o_valid,
    output logic                 o_evt,       // pending retry/drop event
    output logic                 o_evt_drop,
    output logic [31:0]          o_ip
);
    logic        r_valid;
    logic [31:0] r_ip;
    logic [1:0]  r_wait;
    logic [2:0]  r_sends;
    logic        r_evt;
    logic        r_drop;
    logic        w_claim;
    logic        w_due;

    assign w_claim    = !r_valid && !i_free_in;
    assign o_free_out = i_free_in || !r_valid;
    assign o_match    = r_valid && (r_ip == i_cmd.ip);
    assign o_valid    = r_valid;
    assign o_evt      = r_evt;
    assign o_evt_drop = r_drop;
    assign o_ip       = r_ip;
    assign w_due      = r_wait >= i_cmd.interval;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_evt   <= 1'b0;
        end else begin
            if (i_ack) begin
                r_evt <= 1'b0;
            end
            if (i_cmd.wr && w_claim) begin
                r_valid <= 1'b1;
            end else if (i_cmd.clr_hit && o_match) begin
                r_valid <= 1'b0;
            end else if (i_cmd.age && r_valid && w_due) begin
                r_evt <= 1'b1;
                if (r_sends >= i_cmd.limit) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_claim) begin
            r_ip    <= i_cmd.ip;
            r_wait  <= 2'd3;
            r_sends <= 3'd0;
        end else if (i_cmd.age && r_valid) begin
            if (w_due) begin
                r_drop <= r_sends >= i_cmd.limit;
                if (r_sends < i_cmd.limit) begin
                    r_wait  <= 2'd0;
                    r_sends <= (r_sends == 3'd7) ? r_sends : r_sends + 3'd1;
                end
            end else if (r_wait != 2'd3) begin
                r_wait <= r_wait + 2'd1;
            end
        end
    end
endmodule
